// ===== src/segment_offset_lookup_top_defines.svh =====
// ----------------------------------------------------------------------------
// Segment offset lookup: assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_OFFSET_LOOKUP_TOP_DEFINES_SVH
`define SEGMENT_OFFSET_LOOKUP_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define SLT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define SLT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/slt_pkg.sv =====
// ----------------------------------------------------------------------------
// slt_pkg
// Field widths, opcodes, status codes and unit operations of the segment
// offset lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package slt_pkg;

    // Fixed field widths
    localparam int VAL_W = 48;
    localparam int SEG_W = 11;
    localparam int OP_W  = 2;
    localparam int ST_W  = 2;

    // Opcodes
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    // Result status
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_REFUSED   = 2'd2;

    // Shared add/subtract unit operation
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

endpackage

`default_nettype wire

// ===== src/slt_alu.sv =====
// ----------------------------------------------------------------------------
// slt_alu
// Shared add/subtract unit. The result carries one extra bit: the carry
// out of an add, or the borrow of a subtract (set when a < b).
// ----------------------------------------------------------------------------
`default_nettype none

module slt_alu #(
    parameter int W = 48
) (
    input  slt_pkg::t_alu_op i_op,
    input  logic [W-1:0]     i_a,
    input  logic [W-1:0]     i_b,
    output logic [W:0]       o_res
);

    // Zero-extended add or subtract
    always_comb begin
        if (i_op == slt_pkg::ALU_SUB) begin
            o_res = {1'b0, i_a} - {1'b0, i_b};
        end else begin
            o_res = {1'b0, i_a} + {1'b0, i_b};
        end
    end

endmodule

`default_nettype wire

// ===== src/slt_prefix_ram.sv =====
// ----------------------------------------------------------------------------
// slt_prefix_ram
// Prefix sum table: one write port and one read port, read data registered.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_prefix_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/segment_offset_lookup_top.sv =====
// ----------------------------------------------------------------------------
// segment_offset_lookup_top
// Builds a list of consecutive segments and maps a 1-based global position
// onto (segment number, offset inside segment).
//
// Input channel i_valid/o_ready carries opcode and value: clear, append a
// segment size, or query a position. Every transfer gives exactly one result
// on the o_valid/i_ready channel (segment number, offset, status).
// One item is in flight at a time; o_ready is high only when idle.
// Clear and append: the result is registered from the execute step, and
// o_ready returns in the same cycle that the result becomes valid.
// Query: an execute step, then P search probes, then a fetch of the previous
// prefix sum, where P is the number of binary search probes (at most
// clog2(count) + 1, 11 for 1024 segments). Each probe is one prefix table
// read plus one compare in the shared add/subtract unit, so the table read
// port sets the search pace.
// Reset clears the segment count and running total; the table itself is
// not cleared, only entries below the count are used.
// If the receiver stalls, the finished result waits in the output register
// and the sequencer holds in its last step until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_offset_lookup_top #(
    parameter int MAX_SEGMENTS = 1024,
    parameter int SUM_WIDTH    = 48
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [slt_pkg::OP_W-1:0]    i_opcode,
    input  logic [slt_pkg::VAL_W-1:0]   i_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [slt_pkg::SEG_W-1:0]   o_segment_number,
    output logic [slt_pkg::VAL_W-1:0]   o_offset,
    output logic [slt_pkg::ST_W-1:0]    o_status
);

    localparam int VAL_W = slt_pkg::VAL_W;
    localparam int SEG_W = slt_pkg::SEG_W;
    localparam int AW    = $clog2(MAX_SEGMENTS);
    localparam int CNTW  = $clog2(MAX_SEGMENTS + 1);
    localparam int CW    = (SUM_WIDTH > VAL_W) ? SUM_WIDTH : VAL_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXEC   = 4'b0010,
        S_SEARCH = 4'b0100,
        S_PREV   = 4'b1000
    } t_state;

    // Control state
    t_state                  r_state, n_state;
    logic [CNTW-1:0]         r_count, n_count;
    logic [SUM_WIDTH-1:0]    r_total, n_total;
    logic                    r_o_valid;

    // Item and search registers
    logic [slt_pkg::OP_W-1:0] r_op, n_op;
    logic [VAL_W-1:0]         r_val, n_val;
    logic [CNTW-1:0]          r_lo, n_lo;
    logic [CNTW-1:0]          r_hi, n_hi;
    logic [CNTW-1:0]          r_mid, n_mid;

    // Output register
    logic [SEG_W-1:0]         r_seg;
    logic [VAL_W-1:0]         r_off;
    logic [slt_pkg::ST_W-1:0] r_stat;

    // Shared unit
    slt_pkg::t_alu_op alu_op;
    logic [CW-1:0]    alu_a, alu_b;
    logic [CW:0]      alu_res;
    logic             alu_borrow;

    // Table ports
    logic                 ram_we;
    logic [AW-1:0]        ram_raddr;
    logic [SUM_WIDTH-1:0] ram_rdata;

    // Sequencer helpers
    logic                     out_free;
    logic                     emit;
    logic [SEG_W-1:0]         emit_seg;
    logic [VAL_W-1:0]         emit_off;
    logic [slt_pkg::ST_W-1:0] emit_stat;
    logic                     ge;
    logic [CNTW-1:0]          srch_lo, srch_hi, srch_mid, srch_dec, lo_dec;
    logic                     full, ovf;

    slt_alu #(
        .W(CW)
    ) u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    slt_prefix_ram #(
        .DEPTH(MAX_SEGMENTS),
        .WIDTH(SUM_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (alu_res[SUM_WIDTH-1:0]),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign alu_borrow = alu_res[CW];
    assign out_free   = !r_o_valid || i_ready;
    assign o_ready    = (r_state == S_IDLE);

    // Append checks: table full, or total plus size beyond the sum width
    assign full = (r_count >= CNTW'(MAX_SEGMENTS));
    assign ovf  = |alu_res[CW:SUM_WIDTH];

    // One binary search step from the probe just read
    assign ge       = !alu_borrow;
    assign srch_lo  = ge ? r_lo : r_mid + CNTW'(1);
    assign srch_hi  = ge ? r_mid : r_hi;
    assign srch_mid = srch_lo + ((srch_hi - srch_lo) >> 1);
    assign srch_dec = srch_lo - CNTW'(1);
    assign lo_dec   = r_lo - CNTW'(1);

    // Operand selection for the shared unit
    always_comb begin
        alu_op = slt_pkg::ALU_SUB;
        alu_a  = CW'(r_total);
        alu_b  = CW'(r_val);
        case (r_state)
            S_SEARCH: begin
                // probe >= position
                alu_a = CW'(ram_rdata);
                alu_b = CW'(r_val);
            end
            S_PREV: begin
                // offset = position - previous prefix sum
                alu_a = CW'(r_val);
                alu_b = (r_lo == '0) ? '0 : CW'(ram_rdata);
            end
            default: begin
                // append: total + size; query: position above total
                if (r_op == slt_pkg::OP_APPEND) begin
                    alu_op = slt_pkg::ALU_ADD;
                end
            end
        endcase
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_val     = r_val;
        n_count   = r_count;
        n_total   = r_total;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        ram_we    = 1'b0;
        ram_raddr = r_mid[AW-1:0];
        emit      = 1'b0;
        emit_seg  = '0;
        emit_off  = '0;
        emit_stat = slt_pkg::ST_OK;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op    = i_opcode;
                    n_val   = i_value;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                case (r_op)
                    slt_pkg::OP_CLEAR: begin
                        if (out_free) begin
                            emit    = 1'b1;
                            n_count = '0;
                            n_total = '0;
                            n_state = S_IDLE;
                        end
                    end
                    slt_pkg::OP_APPEND: begin
                        if (out_free) begin
                            emit    = 1'b1;
                            n_state = S_IDLE;
                            if (full || ovf) begin
                                emit_stat = slt_pkg::ST_REFUSED;
                            end else begin
                                ram_we  = 1'b1;
                                n_total = alu_res[SUM_WIDTH-1:0];
                                n_count = r_count + CNTW'(1);
                            end
                        end
                    end
                    slt_pkg::OP_QUERY: begin
                        if (r_count == '0 || r_val == '0 || alu_borrow) begin
                            // empty list, position zero or above the total
                            if (out_free) begin
                                emit      = 1'b1;
                                emit_stat = slt_pkg::ST_NOT_FOUND;
                                n_state   = S_IDLE;
                            end
                        end else begin
                            // first probe at the middle of [0, count)
                            n_lo      = '0;
                            n_hi      = r_count;
                            n_mid     = r_count >> 1;
                            ram_raddr = n_mid[AW-1:0];
                            n_state   = S_SEARCH;
                        end
                    end
                    default: begin
                        // unused opcode: no state change, zero result
                        if (out_free) begin
                            emit    = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end

            S_SEARCH: begin
                if (srch_lo < srch_hi) begin
                    n_lo      = srch_lo;
                    n_hi      = srch_hi;
                    n_mid     = srch_mid;
                    ram_raddr = srch_mid[AW-1:0];
                end else begin
                    // bound found: fetch the previous prefix sum
                    n_lo      = srch_lo;
                    ram_raddr = srch_dec[AW-1:0];
                    n_state   = S_PREV;
                end
            end

            S_PREV: begin
                ram_raddr = lo_dec[AW-1:0];
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    if (r_lo >= r_count) begin
                        emit_stat = slt_pkg::ST_NOT_FOUND;
                    end else begin
                        emit_seg = SEG_W'(r_lo + CNTW'(1));
                        emit_off = alu_res[VAL_W-1:0];
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_total   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_total <= n_total;
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_val <= n_val;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        if (emit) begin
            r_seg  <= emit_seg;
            r_off  <= emit_off;
            r_stat <= emit_stat;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_segment_number = r_seg;
    assign o_offset         = r_off;
    assign o_status         = r_stat;

endmodule

`default_nettype wire

// ===== src/slt_checker.sv =====
// ----------------------------------------------------------------------------
// slt_checker
// Port-level checks of the segment offset lookup block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "segment_offset_lookup_top_defines.svh"

module slt_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [slt_pkg::SEG_W-1:0] i_seg,
    input logic [slt_pkg::VAL_W-1:0] i_off,
    input logic [slt_pkg::ST_W-1:0]  i_stat
);

    // A stalled result holds
    `SLT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_seg) && $stable(i_off) && $stable(i_stat), "stalled result changed")

    // Busy right after an input transfer
    `SLT_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "ready after input transfer")

    // Not-found and refused results carry zero fields
    `SLT_ASSERT_SAME(a_fail_zero, i_clk, i_rst_n, i_out_valid && (i_stat == slt_pkg::ST_NOT_FOUND || i_stat == slt_pkg::ST_REFUSED), i_seg == '0 && i_off == '0, "failed result with nonzero fields")

    // A found position has a 1-based offset
    `SLT_ASSERT_SAME(a_found_off, i_clk, i_rst_n, i_out_valid && i_stat == slt_pkg::ST_OK && i_seg != '0, i_off != '0, "found query with zero offset")

endmodule

bind segment_offset_lookup_top slt_checker u_slt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_valid),
    .i_in_ready  (o_ready),
    .i_out_valid (o_valid),
    .i_out_ready (i_ready),
    .i_seg       (o_segment_number),
    .i_off       (o_offset),
    .i_stat      (o_status)
);

`default_nettype wire

// ===== sim/segment_offset_lookup_checker.sv =====
// ----------------------------------------------------------------------------
// segment_offset_lookup_checker
// Watches both channels of the segment offset lookup block. Keeps its own
// prefix-sum table, predicts one result per input transfer and compares every
// output transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_offset_lookup_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic [slt_pkg::OP_W-1:0]  i_opcode,
    input  logic [slt_pkg::VAL_W-1:0] i_value,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [slt_pkg::SEG_W-1:0] i_segment_number,
    input  logic [slt_pkg::VAL_W-1:0] i_offset,
    input  logic [slt_pkg::ST_W-1:0]  i_status,
    input  logic                      i_finish,
    output int unsigned               o_fail_count,
    output int unsigned               o_result_count
);

    localparam int                        TABLE_DEPTH = 1024;
    localparam logic [slt_pkg::VAL_W-1:0] SUM_MAX     = '1;
    localparam int unsigned               PRINT_CAP   = 50;

    typedef struct packed {
        logic [slt_pkg::SEG_W-1:0] segment;
        logic [slt_pkg::VAL_W-1:0] offset;
        logic [slt_pkg::ST_W-1:0]  status;
    } t_lookup_result;

    // Predictor state
    logic [slt_pkg::VAL_W-1:0] prefix_sums [TABLE_DEPTH];
    int unsigned               seg_count = 0;
    logic [slt_pkg::VAL_W-1:0] total_len = '0;

    t_lookup_result   pending_q [$];
    int unsigned      fail_count   = 0;
    int unsigned      result_count = 0;
    bit               end_checked  = 1'b0;

    assign o_fail_count   = fail_count;
    assign o_result_count = result_count;

    task automatic report_mismatch(input string what);
        if (fail_count < PRINT_CAP) begin
            $display("[%0t] lookup check: %s", $time, what);
        end
        fail_count++;
    endtask

    // Apply one input transfer to the shadow table, return the expected result
    function automatic t_lookup_result apply_item(input logic [slt_pkg::OP_W-1:0] op,
                                                  input logic [slt_pkg::VAL_W-1:0] val);
        t_lookup_result            res;
        int unsigned               lo;
        int unsigned               hi;
        int unsigned               mid;
        logic [slt_pkg::VAL_W-1:0] base;
        res = '0;
        case (op)
            slt_pkg::OP_CLEAR: begin
                seg_count = 0;
                total_len = '0;
            end
            slt_pkg::OP_APPEND: begin
                // full table or sum overflow: refused, nothing changes
                if (seg_count >= TABLE_DEPTH || val > SUM_MAX - total_len) begin
                    res.status = slt_pkg::ST_REFUSED;
                end else begin
                    total_len = total_len + val;
                    prefix_sums[seg_count] = total_len;
                    seg_count++;
                end
            end
            slt_pkg::OP_QUERY: begin
                if (seg_count == 0 || val == '0 || val > total_len) begin
                    res.status = slt_pkg::ST_NOT_FOUND;
                end else begin
                    // lower bound: first prefix sum not below the position
                    lo = 0;
                    hi = seg_count;
                    while (lo < hi) begin
                        mid = lo + (hi - lo) / 2;
                        if (prefix_sums[mid] >= val) begin
                            hi = mid;
                        end else begin
                            lo = mid + 1;
                        end
                    end
                    base = (lo == 0) ? '0 : prefix_sums[lo-1];
                    res.segment = slt_pkg::SEG_W'(lo + 1);
                    res.offset  = val - base;
                end
            end
            default: begin
                // unused opcode: all-zero result, state untouched
            end
        endcase
        return res;
    endfunction

    // Compare output transfers, then record the prediction for input transfers
    always @(posedge i_clk) begin
        t_lookup_result want;
        if (!i_rst_n) begin
            seg_count = 0;
            total_len = '0;
            pending_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                result_count++;
                if (pending_q.size() == 0) begin
                    report_mismatch($sformatf(
                        "result with nothing pending: seg %0d offset 0x%0h status %0d",
                        i_segment_number, i_offset, i_status));
                end else begin
                    want = pending_q.pop_front();
                    if (i_segment_number !== want.segment) begin
                        report_mismatch($sformatf("segment number %0d, expected %0d",
                                                  i_segment_number, want.segment));
                    end
                    if (i_offset !== want.offset) begin
                        report_mismatch($sformatf("offset 0x%0h, expected 0x%0h",
                                                  i_offset, want.offset));
                    end
                    if (i_status !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_status, want.status));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                pending_q.insert(pending_q.size(), apply_item(i_opcode, i_value));
            end
            if (i_finish && !end_checked) begin
                end_checked = 1'b1;
                if (pending_q.size() != 0) begin
                    report_mismatch($sformatf("%0d results never arrived",
                                              pending_q.size()));
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== sim/segment_offset_lookup_top_test.sv =====
// ----------------------------------------------------------------------------
// segment_offset_lookup_top_test
// Drives clear, append and query transfers into the segment offset lookup
// block: a directed set of edge cases, then random build and search
// sequences under several sender idle and receiver stall mixes.
// A separate checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_offset_lookup_top_test;

    localparam logic [slt_pkg::OP_W-1:0]  OP_RESERVED     = 2'd3;
    localparam int                        TABLE_DEPTH     = 1024;
    localparam logic [slt_pkg::VAL_W-1:0] SUM_MAX         = '1;
    localparam int                        ITEMS_PER_PHASE = 85;
    localparam int                        TAIL_CYCLES     = 40;

    logic                      i_clk    = 1'b0;
    logic                      i_rst_n  = 1'b0;
    logic                      i_valid  = 1'b0;
    logic [slt_pkg::OP_W-1:0]  i_opcode = slt_pkg::OP_CLEAR;
    logic [slt_pkg::VAL_W-1:0] i_value  = '0;
    logic                      i_ready  = 1'b0;
    logic                      check_end = 1'b0;
    wire                       o_ready;
    wire                       o_valid;
    wire [slt_pkg::SEG_W-1:0]  o_segment_number;
    wire [slt_pkg::VAL_W-1:0]  o_offset;
    wire [slt_pkg::ST_W-1:0]   o_status;
    int unsigned               fail_count;
    int unsigned               result_count;

    // Traffic shaping and bookkeeping
    int               send_idle_pct  = 0;
    int               recv_stall_pct = 0;
    int unsigned      n_sent    = 0;
    int unsigned      n_results = 0;
    int unsigned      op_seen [4] = '{default: 0};

    // Rough image of the table, used only to aim query positions
    logic [slt_pkg::VAL_W-1:0] plan_sums [$];
    logic [slt_pkg::VAL_W-1:0] plan_total = '0;

    segment_offset_lookup_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_opcode         (i_opcode),
        .i_value          (i_value),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_segment_number (o_segment_number),
        .o_offset         (o_offset),
        .o_status         (o_status)
    );

    segment_offset_lookup_checker checker_u (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_ready       (o_ready),
        .i_opcode         (i_opcode),
        .i_value          (i_value),
        .i_out_valid      (o_valid),
        .i_out_ready      (i_ready),
        .i_segment_number (o_segment_number),
        .i_offset         (o_offset),
        .i_status         (o_status),
        .i_finish         (check_end),
        .o_fail_count     (fail_count),
        .o_result_count   (result_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: random stalls, count result transfers
    always @(posedge i_clk) begin
        if (o_valid && i_ready) begin
            n_results <= n_results + 1;
        end
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [slt_pkg::VAL_W-1:0] rand_value();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[slt_pkg::VAL_W-1:0];
    endfunction

    // Segment size of random magnitude, zero now and then
    function automatic logic [slt_pkg::VAL_W-1:0] rand_size();
        int unsigned w;
        if ($urandom_range(99) < 10) begin
            return '0;
        end
        w = $urandom_range(slt_pkg::VAL_W);
        return rand_value() >> (slt_pkg::VAL_W - w);
    endfunction

    // Query position: mostly inside the list, often on a segment boundary
    function automatic logic [slt_pkg::VAL_W-1:0] pick_position();
        int unsigned               pick;
        logic [63:0]               r;
        logic [slt_pkg::VAL_W-1:0] b;
        pick = $urandom_range(99);
        if (plan_total == '0 || pick < 10) begin
            return rand_value();
        end
        if (pick < 40) begin
            b = plan_sums[$urandom_range(plan_sums.size() - 1)];
            case ($urandom_range(2))
                0: return b - 1'b1;
                1: return b;
                default: return b + 1'b1;
            endcase
        end
        if (pick < 45) begin
            return plan_total + 1'b1;
        end
        r = {$urandom, $urandom};
        return slt_pkg::VAL_W'(64'd1 + r % {16'd0, plan_total});
    endfunction

    // One input transfer, with random idle cycles ahead of it
    task automatic send_item(input logic [slt_pkg::OP_W-1:0] op,
                             input logic [slt_pkg::VAL_W-1:0] val);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid  <= 1'b1;
        i_opcode <= op;
        i_value  <= val;
        do @(posedge i_clk); while (!o_ready);
        n_sent++;
        op_seen[op]++;
        case (op)
            slt_pkg::OP_CLEAR: begin
                plan_sums.delete();
                plan_total = '0;
            end
            slt_pkg::OP_APPEND: begin
                if (plan_sums.size() < TABLE_DEPTH && val <= SUM_MAX - plan_total) begin
                    plan_total = plan_total + val;
                    plan_sums.insert(plan_sums.size(), plan_total);
                end
            end
            default: begin
            end
        endcase
    endtask

    // Hold off the sender until every result is back
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (n_results != n_sent);
    endtask

    // Build a few segments, then search them
    task automatic run_sequence();
        int n_app;
        int n_qry;
        n_app = $urandom_range(12, 1);
        n_qry = $urandom_range(8, 1);
        if ($urandom_range(99) < 70) begin
            send_item(slt_pkg::OP_CLEAR, rand_value());
        end
        repeat (n_app) send_item(slt_pkg::OP_APPEND, rand_size());
        repeat (n_qry) send_item(slt_pkg::OP_QUERY, pick_position());
    endtask

    initial begin
        int unsigned phase_start;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, zero-sized segments, boundaries, overflow
        send_item(slt_pkg::OP_QUERY, 48'd5);
        send_item(OP_RESERVED, SUM_MAX);
        send_item(slt_pkg::OP_APPEND, 48'd0);
        send_item(slt_pkg::OP_APPEND, 48'd5);
        send_item(slt_pkg::OP_APPEND, 48'd0);
        send_item(slt_pkg::OP_APPEND, 48'd7);
        send_item(slt_pkg::OP_QUERY, 48'd0);
        send_item(slt_pkg::OP_QUERY, 48'd1);
        send_item(slt_pkg::OP_QUERY, 48'd5);
        send_item(slt_pkg::OP_QUERY, 48'd6);
        send_item(slt_pkg::OP_QUERY, 48'd12);
        send_item(slt_pkg::OP_QUERY, 48'd13);
        send_item(slt_pkg::OP_QUERY, SUM_MAX);
        send_item(slt_pkg::OP_APPEND, SUM_MAX - 48'd12);
        send_item(slt_pkg::OP_APPEND, 48'd1);
        send_item(slt_pkg::OP_APPEND, SUM_MAX);
        send_item(slt_pkg::OP_QUERY, SUM_MAX);
        send_item(slt_pkg::OP_QUERY, 48'd13);
        send_item(slt_pkg::OP_CLEAR, 48'd0);
        send_item(slt_pkg::OP_APPEND, SUM_MAX);
        send_item(slt_pkg::OP_QUERY, SUM_MAX);
        send_item(slt_pkg::OP_QUERY, 48'd1);
        send_item(OP_RESERVED, 48'd0);
        send_item(slt_pkg::OP_CLEAR, SUM_MAX);
        send_item(slt_pkg::OP_QUERY, 48'd1);
        drain();

        // Random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            phase_start = n_sent;
            while (n_sent - phase_start < ITEMS_PER_PHASE) begin
                if ($urandom_range(99) < 85) begin
                    run_sequence();
                end else begin
                    send_item(slt_pkg::OP_W'($urandom_range(3)), rand_value());
                end
            end
            drain();
        end

        // Let the pipe settle, then close out the checker
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        check_end <= 1'b1;
        repeat (2) @(posedge i_clk);

        $display("covered %0d transfers: %0d clear, %0d append, %0d query, %0d unused opcode",
                 n_sent, op_seen[slt_pkg::OP_CLEAR], op_seen[slt_pkg::OP_APPEND],
                 op_seen[slt_pkg::OP_QUERY], op_seen[OP_RESERVED]);
        $display("%0d results checked, directed corner cases and four idle/stall mixes",
                 result_count);
        if (fail_count == 0) begin
            $display("segment_offset_lookup_top regression: pass");
        end else begin
            $display("segment_offset_lookup_top regression: fail");
        end
        $finish;
    end

    // Hard stop if the handshakes hang
    initial begin
        #5000000;
        $display("segment_offset_lookup_top regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
